### hdl/rac_pkg.sv
package rac_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned BtnW   = 5;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CntW-1:0] SegSecsRst = CntW'(2);
  localparam logic [CntW-1:0] TotSecsRst = CntW'(10);
  localparam logic [CntW-1:0] CntMax     = {CntW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEG_SECS = 1'b0,
    REG_TOT_SECS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    CODE_NONE   = 3'd0,
    CODE_AUTO   = 3'd1,
    CODE_MANUAL = 3'd2,
    CODE_RIGHT  = 3'd3,
    CODE_LEFT   = 3'd4,
    CODE_STOP   = 3'd5
  } btn_code_e;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_e;

  typedef struct packed {
    logic [BtnW-1:0] buttons;
    logic            second_tick;
  } item_t;

  typedef struct packed {
    logic             drive_right;
    logic             drive_left;
    logic [ModeW-1:0] mode_status;
  } res_t;

  // lowest-numbered pressed button wins
  function automatic btn_code_e btn_code(input logic [BtnW-1:0] b);
    btn_code_e c;
    if (b[0])      c = CODE_AUTO;
    else if (b[1]) c = CODE_MANUAL;
    else if (b[2]) c = CODE_RIGHT;
    else if (b[3]) c = CODE_LEFT;
    else if (b[4]) c = CODE_STOP;
    else           c = CODE_NONE;
    return c;
  endfunction

endpackage

### hdl/rac_if.sv
interface rac_in_if;
  import rac_pkg::*;
  logic                valid;
  logic                ready;
  logic [BtnW-1:0]     buttons;
  logic                second_tick;

  modport source (output valid, output buttons, output second_tick, input ready);
  modport sink   (input valid, input buttons, input second_tick, output ready);
endinterface

interface rac_out_if;
  import rac_pkg::*;
  logic             valid;
  logic             ready;
  logic             drive_right;
  logic             drive_left;
  logic [ModeW-1:0] mode_status;

  modport source (output valid, output drive_right, output drive_left,
                  output mode_status, input ready);
  modport sink   (input valid, input drive_right, input drive_left,
                  input mode_status, output ready);
endinterface

### hdl/rac_in_reg.sv
module rac_in_reg import rac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rac_in_if.sink      in_i,
  input  logic        adv_i,
  output logic        vld_o,
  output item_t       item_o
);

  logic  vld_q, vld_d;
  item_t item_q;
  logic  load;

  assign in_i.ready = !vld_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.buttons     <= in_i.buttons;
      item_q.second_tick <= in_i.second_tick;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

### hdl/rac_ctrl.sv
module rac_ctrl import rac_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  item_t           item_i,
  input  logic [CntW-1:0] seg_secs_i,
  input  logic [CntW-1:0] tot_secs_i,
  output res_t            res_o
);

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_AUTO_R   = 6'b000010,
    PH_AUTO_L   = 6'b000100,
    PH_MAN_WAIT = 6'b001000,
    PH_MAN_R    = 6'b010000,
    PH_MAN_L    = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] seg_q, seg_d, tot_q, tot_d;
  logic [CntW-1:0] seg_inc, tot_inc;
  btn_code_e       code;

  assign code    = btn_code(item_i.buttons);
  assign seg_inc = (seg_q == CntMax) ? CntMax : seg_q + CntW'(1);
  assign tot_inc = (tot_q == CntMax) ? CntMax : tot_q + CntW'(1);

  always_comb begin
    phase_d = phase_q;
    seg_d   = seg_q;
    tot_d   = tot_q;
    case (phase_q)
      PH_AUTO_R, PH_AUTO_L: begin
        if (code == CODE_STOP) begin
          phase_d = PH_IDLE;
        end else if (item_i.second_tick) begin
          seg_d = seg_inc;
          tot_d = tot_inc;
          if (seg_inc >= seg_secs_i) begin
            seg_d = '0;
            if (phase_q == PH_AUTO_R) begin
              phase_d = PH_AUTO_L;
            end else if (tot_inc >= tot_secs_i) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_AUTO_R;
            end
          end
        end
      end
      PH_MAN_WAIT: begin
        if (code == CODE_AUTO) begin
          phase_d = PH_IDLE;
        end else if (code == CODE_RIGHT) begin
          phase_d = PH_MAN_R;
        end else if (code == CODE_LEFT) begin
          phase_d = PH_MAN_L;
        end
      end
      PH_MAN_R, PH_MAN_L: begin
        if (code == CODE_STOP) begin
          phase_d = PH_MAN_WAIT;
        end
      end
      default: begin
        // idle, and any illegal code
        phase_d = PH_IDLE;
        if (code == CODE_AUTO) begin
          phase_d = PH_AUTO_R;
          seg_d   = '0;
          tot_d   = '0;
        end else if (code == CODE_MANUAL) begin
          phase_d = PH_MAN_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seg_q   <= '0;
      tot_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      seg_q   <= seg_d;
      tot_q   <= tot_d;
    end
  end

  always_comb begin
    res_o.drive_right = (phase_d == PH_AUTO_R) || (phase_d == PH_MAN_R);
    res_o.drive_left  = (phase_d == PH_AUTO_L) || (phase_d == PH_MAN_L);
    case (phase_d)
      PH_AUTO_R, PH_AUTO_L:           res_o.mode_status = MODE_AUTO;
      PH_MAN_WAIT, PH_MAN_R, PH_MAN_L: res_o.mode_status = MODE_MANUAL;
      default:                         res_o.mode_status = MODE_IDLE;
    endcase
  end

endmodule

### hdl/reversing_agitator_controller.sv
// Channel | Dir | Payload                               | Handshake
// in_i    | in  | buttons[4:0], second_tick             | valid/ready
// out_o   | out | drive_right, drive_left, mode_status  | valid/ready
// cfg     | in  | cfg_idx_i, cfg_data_i[15:0]           | cfg_we_i
//
// One word per cycle sustained while the output is not stalled.
// The input register feeds the phase/counter update, which loads the output register.
// A stalled output holds the result and the word behind it; input stays ready while
// the input register is empty or moving.
// Reset: idle phase, counters zero, segment 2 s, total 10 s.
module reversing_agitator_controller import rac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  rac_in_if.sink             in_i,
  rac_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_data_i
);

  logic            in_vld, adv, step;
  item_t           item;
  res_t            res, res_q;
  logic            out_vld_q, out_vld_d;
  logic [CntW-1:0] seg_secs_q, tot_secs_q;

  assign adv  = !out_vld_q || out_o.ready;
  assign step = in_vld && adv;

  rac_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .vld_o  (in_vld),
    .item_o (item)
  );

  rac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .seg_secs_i (seg_secs_q),
    .tot_secs_i (tot_secs_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_secs_q <= SegSecsRst;
      tot_secs_q <= TotSecsRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SEG_SECS: seg_secs_q <= cfg_data_i;
        REG_TOT_SECS: tot_secs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.drive_right = res_q.drive_right;
  assign out_o.drive_left  = res_q.drive_left;
  assign out_o.mode_status = res_q.mode_status;

`ifndef SYNTHESIS
  a_one_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.drive_right && res_q.drive_left))
    else $error("both drive directions active");

  a_idle_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.mode_status == MODE_IDLE) |->
      !(res_q.drive_right || res_q.drive_left))
    else $error("motor driven while idle");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.mode_status == MODE_IDLE || res_q.mode_status == MODE_AUTO ||
                   res_q.mode_status == MODE_MANUAL))
    else $error("illegal mode status");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld && !adv) |=> in_vld)
    else $error("input word dropped under output stall");
`endif

endmodule

### sim/rac_checker.sv
module rac_checker import rac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  rac_in_if                  in_mon,
  rac_out_if                 out_mon,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_data_i,
  output int                 err_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 runs_done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AUTO_R,
    ST_AUTO_L,
    ST_MAN_WAIT,
    ST_MAN_R,
    ST_MAN_L
  } stir_e;

  stir_e           st;
  logic [CntW-1:0] seg_cnt;
  logic [CntW-1:0] tot_cnt;
  logic [CntW-1:0] seg_len;
  logic [CntW-1:0] run_len;
  res_t            drive_q[$];
  int              errs;
  int              checked;
  int              runs_done;

  function automatic btn_code_e press_code(input logic [BtnW-1:0] b);
    btn_code_e c;
    casez (b)
      5'b????1: c = CODE_AUTO;
      5'b???10: c = CODE_MANUAL;
      5'b??100: c = CODE_RIGHT;
      5'b?1000: c = CODE_LEFT;
      5'b10000: c = CODE_STOP;
      default:  c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  // advances the stirring state by one button sample, returns the motor drive and mode status
  function automatic res_t stir_step(input logic [BtnW-1:0] b, input logic tick);
    btn_code_e code;
    res_t      r;
    code = press_code(b);
    case (st)
      ST_IDLE: begin
        if (code == CODE_AUTO) begin
          st      = ST_AUTO_R;
          seg_cnt = '0;
          tot_cnt = '0;
        end else if (code == CODE_MANUAL) begin
          st = ST_MAN_WAIT;
        end
      end
      ST_AUTO_R, ST_AUTO_L: begin
        if (code == CODE_STOP) begin
          st = ST_IDLE;
        end else if (tick) begin
          seg_cnt = bump(seg_cnt);
          tot_cnt = bump(tot_cnt);
          if (seg_cnt >= seg_len) begin
            seg_cnt = '0;
            if (st == ST_AUTO_R) begin
              st = ST_AUTO_L;
            end else if (tot_cnt >= run_len) begin
              st = ST_IDLE;
              runs_done++;
            end else begin
              st = ST_AUTO_R;
            end
          end
        end
      end
      ST_MAN_WAIT: begin
        if (code == CODE_AUTO) st = ST_IDLE;
        else if (code == CODE_RIGHT) st = ST_MAN_R;
        else if (code == CODE_LEFT) st = ST_MAN_L;
      end
      default: begin
        if (code == CODE_STOP) st = ST_MAN_WAIT;
      end
    endcase
    r.drive_right = st inside {ST_AUTO_R, ST_MAN_R};
    r.drive_left  = st inside {ST_AUTO_L, ST_MAN_L};
    if (st == ST_IDLE) r.mode_status = MODE_IDLE;
    else if (st inside {ST_AUTO_R, ST_AUTO_L}) r.mode_status = MODE_AUTO;
    else r.mode_status = MODE_MANUAL;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      st        = ST_IDLE;
      seg_cnt   = '0;
      tot_cnt   = '0;
      seg_len   = 16'd2;
      run_len   = 16'd10;
      errs      = 0;
      checked   = 0;
      runs_done = 0;
      drive_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEG_SECS: seg_len = cfg_data_i;
          REG_TOT_SECS: run_len = cfg_data_i;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_q.size() == 0) begin
          errs++;
          $display("%0t: expected no word, got right=%0b left=%0b mode=%0d", $time,
                   out_mon.drive_right, out_mon.drive_left, out_mon.mode_status);
        end else begin
          want = drive_q.pop_front();
          checked++;
          if (out_mon.drive_right !== want.drive_right ||
              out_mon.drive_left !== want.drive_left ||
              out_mon.mode_status !== want.mode_status) begin
            errs++;
            $display("%0t: expected right=%0b left=%0b mode=%0d, got right=%0b left=%0b mode=%0d",
                     $time, want.drive_right, want.drive_left, want.mode_status,
                     out_mon.drive_right, out_mon.drive_left, out_mon.mode_status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        drive_q.push_back(stir_step(in_mon.buttons, in_mon.second_tick));
    end
    err_o       <= errs;
    pending_o   <= drive_q.size();
    checked_o   <= checked;
    runs_done_o <= runs_done;
  end

endmodule

### sim/tb_top.sv
module tb_top;
  import rac_pkg::*;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  reg_idx_e        cfg_idx;
  logic [CntW-1:0] cfg_data;
  logic            calm;
  int              hold_len;
  int              words_sent;
  int              settings_used;
  int              err_cnt;
  int              pending;
  int              checked;
  int              runs_done;

  rac_in_if  in_ch ();
  rac_out_if out_ch ();

  reversing_agitator_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rac_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_o       (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .runs_done_o (runs_done)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #15_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

  // output side: random back-pressure, plus one long counted hold-off
  initial begin : sink_side
    int held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        for (held = 1; held < hold_len; held++) @(posedge clk_i);
        hold_len = 0;
      end else begin
        out_ch.ready <= rst_ni && (calm || $urandom_range(99) >= 9);
      end
    end
  end

  task automatic send_word(input logic [BtnW-1:0] b, input logic tick);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.buttons     <= b;
    in_ch.second_tick <= tick;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CntW-1:0] seg, input logic [CntW-1:0] tot);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SEG_SECS;
    cfg_data <= seg;
    @(posedge clk_i);
    cfg_idx  <= REG_TOT_SECS;
    cfg_data <= tot;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [BtnW-1:0] noise_buttons();
    int r;
    r = $urandom_range(99);
    if (r < 75) return '0;
    if (r < 93) return 5'(5'b00010 << $urandom_range(2));
    return 5'($urandom);
  endfunction

  task automatic random_words(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      case ($urandom_range(3))
        0: begin
          send_word({4'($urandom), 1'b1}, 1'($urandom));
          repeat ($urandom_range(40, 1)) send_word(noise_buttons(), 1'($urandom));
        end
        1: begin
          send_word({3'($urandom), 2'b10}, 1'($urandom));
          repeat ($urandom_range(12, 1)) send_word(noise_buttons(), 1'($urandom));
          send_word(5'b10000, 1'($urandom));
          if ($urandom_range(1)) send_word({4'($urandom), 1'b1}, 1'($urandom));
        end
        default: begin
          repeat ($urandom_range(8, 1)) send_word(5'($urandom), 1'($urandom));
        end
      endcase
    end
  endtask

  initial begin : stim
    int waited;
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.buttons     <= '0;
    in_ch.second_tick <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_SEG_SECS;
    cfg_data          <= '0;
    calm              = 1'b0;
    hold_len          = 0;
    words_sent        = 0;
    settings_used     = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 2 s segments, 10 s total
    send_word(5'b00000, 1'b1);
    send_word(5'b11111, 1'b1);  // auto wins, tick not counted
    send_word(5'b00000, 1'b1);
    send_word(5'b01110, 1'b1);  // ignored in auto, segment ends
    send_word(5'b00001, 1'b1);
    send_word(5'b10000, 1'b1);  // stop beats tick
    send_word(5'b11110, 1'b0);
    send_word(5'b11100, 1'b0);
    send_word(5'b01001, 1'b1);  // ignored while running manually
    send_word(5'b10000, 1'b0);
    send_word(5'b11000, 1'b0);
    send_word(5'b10000, 1'b0);
    send_word(5'b10000, 1'b0);
    send_word(5'b00011, 1'b0);  // auto leaves manual
    send_word(5'b00001, 1'b1);  // still held: auto starts
    send_word(5'b00000, 1'b1);
    send_word(5'b00000, 1'b1);
    settle();
    set_regs(16'd0, 16'd0);
    send_word(5'b00001, 1'b0);
    send_word(5'b00000, 1'b1);
    send_word(5'b00000, 1'b1);
    send_word(5'b00000, 1'b1);
    settle();

    set_regs(16'd1, 16'd1);
    random_words(250);
    settle();
    set_regs(16'd0, 16'd0);
    random_words(150);
    settle();
    set_regs(16'd3, 16'd7);
    hold_len = 200;
    random_words(300);
    settle();
    set_regs(16'hFFFF, 16'hFFFF);
    random_words(150);
    settle();
    calm = 1'b1;
    set_regs(16'($urandom_range(5, 1)), 16'($urandom_range(25, 1)));
    random_words(300);
    settle();
    calm = 1'b0;
    set_regs(16'($urandom), 16'($urandom));
    random_words(100);
    settle();
    set_regs(16'd2, 16'd10);
    random_words(250);

    in_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    $display("Sent %0d button words over %0d register settings; %0d results checked,",
             words_sent, settings_used, checked);
    $display("%0d automatic runs ended at their time limit.", runs_done);
    if (err_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
